[rtl/core/ecal_pkg.sv]
// Shared types, constants and microcode ROM for the epoch-to-calendar converter.
`default_nettype none

package ecal_pkg;

    // Seconds in one day, one hour and one minute, and days in one week.
    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned DaysPerWeek = 7;

    // Field widths.
    localparam int unsigned EpochW = 31;
    localparam int unsigned DaysW  = 15;
    localparam int unsigned TodW   = 17;
    localparam int unsigned DivW   = 17;
    localparam int unsigned DivInW = 24;
    localparam int unsigned RecW   = 25;
    localparam int unsigned ProdW  = DivInW + RecW;
    localparam int unsigned QdW    = DaysW + DivW;
    localparam int unsigned PcW    = 4;

    // Reciprocal division: quotient = ((x >> pre) * recip) >> post. Each reciprocal is
    // rounded up and is exact over the whole range of its dividend.
    localparam int unsigned PreDay   = 7;    // 86400 = 128 * 675
    localparam int unsigned PreWeek  = 0;
    localparam int unsigned PreHour  = 4;    // 3600 = 16 * 225
    localparam int unsigned PreMin   = 2;    // 60 = 4 * 15
    localparam int unsigned PostDay  = 34;
    localparam int unsigned PostWeek = 18;
    localparam int unsigned PostHour = 21;
    localparam int unsigned PostMin  = 14;
    localparam logic [RecW-1:0] RecipDay  = 25'd25451659;  // 2^34 / 675
    localparam logic [RecW-1:0] RecipWeek = 25'd37450;     // 2^18 / 7
    localparam logic [RecW-1:0] RecipHour = 25'd9321;      // 2^21 / 225
    localparam logic [RecW-1:0] RecipMin  = 25'd1093;      // 2^14 / 15

    // Year 1970 counted from 1900, and the weekday of 1970-01-01 (Thursday).
    localparam logic [7:0] FirstYearOff = 8'd70;
    localparam logic [2:0] EpochWeekday = 3'd4;

    localparam logic [PcW-1:0] LastPc = 4'd11;

    // Datapath operations, one per microcode step.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DIV,
        OP_SAVE_DAYS,
        OP_SAVE_WDAY,
        OP_SAVE_HOUR,
        OP_SAVE_MS,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } op_t;

    // Condition that moves the program counter to the step's target.
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,
        COND_FITS,
        COND_OUT_FREE
    } cond_t;

    // Divisor selection for the shared divider.
    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_WEEK,
        DSEL_HOUR,
        DSEL_MIN
    } dsel_t;

    // One control word of the program.
    typedef struct packed {
        op_t            op;
        cond_t          cond;
        dsel_t          dsel;
        logic [PcW-1:0] target;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        op_t            op;
        dsel_t          dsel;
        logic           go;
    } ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic fits;
    } stat_t;

    // Finished calendar fields.
    typedef struct packed {
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic [7:0] years_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_t;

    // The conversion program. Each division is a quotient step followed by a save
    // step that forms the remainder with the same divisor.
    function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
        ucode_t w;
        w = '{op: OP_IDLE, cond: COND_ALWAYS, dsel: DSEL_DAY, target: '0};
        unique case (pc)
            4'd0:  w = '{OP_IDLE,      COND_IN,       DSEL_DAY,  4'd1};
            4'd1:  w = '{OP_DIV,       COND_ALWAYS,   DSEL_DAY,  4'd2};
            4'd2:  w = '{OP_SAVE_DAYS, COND_ALWAYS,   DSEL_DAY,  4'd3};
            4'd3:  w = '{OP_DIV,       COND_ALWAYS,   DSEL_WEEK, 4'd4};
            4'd4:  w = '{OP_SAVE_WDAY, COND_ALWAYS,   DSEL_WEEK, 4'd5};
            4'd5:  w = '{OP_DIV,       COND_ALWAYS,   DSEL_HOUR, 4'd6};
            4'd6:  w = '{OP_SAVE_HOUR, COND_ALWAYS,   DSEL_HOUR, 4'd7};
            4'd7:  w = '{OP_DIV,       COND_ALWAYS,   DSEL_MIN,  4'd8};
            4'd8:  w = '{OP_SAVE_MS,   COND_ALWAYS,   DSEL_MIN,  4'd9};
            4'd9:  w = '{OP_YEAR,      COND_FITS,     DSEL_DAY,  4'd10};
            4'd10: w = '{OP_MONTH,     COND_FITS,     DSEL_DAY,  4'd11};
            4'd11: w = '{OP_EMIT,      COND_OUT_FREE, DSEL_DAY,  4'd0};
            default: w = '{OP_IDLE,    COND_ALWAYS,   DSEL_DAY,  4'd0};
        endcase
        return w;
    endfunction

    // Divisor constants.
    function automatic logic [DivW-1:0] divisor(input dsel_t sel);
        logic [DivW-1:0] d;
        d = '0;
        unique case (sel)
            DSEL_DAY:  d = DivW'(SecsPerDay);
            DSEL_WEEK: d = DivW'(DaysPerWeek);
            DSEL_HOUR: d = DivW'(SecsPerHour);
            DSEL_MIN:  d = DivW'(SecsPerMin);
            default:   d = DivW'(SecsPerDay);
        endcase
        return d;
    endfunction

    // Month lengths of a common year.
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd1:                     len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ecal_dp.sv]
// Datapath of the epoch-to-calendar converter: divider, year and month walk.
`default_nettype none

module ecal_dp (
    input  wire logic                              aclk,
    input  wire logic [ecal_pkg::EpochW-1:0]       epoch_seconds,
    input  wire ecal_pkg::ctrl_t                   ctrl,
    output ecal_pkg::stat_t                        stat,
    output ecal_pkg::cal_t                         cal
);

    logic [ecal_pkg::EpochW-1:0] num_reg, num_next;
    logic [ecal_pkg::DaysW-1:0]  quo_reg, quo_next;
    logic [ecal_pkg::DaysW-1:0]  days_reg, days_next;
    logic [ecal_pkg::TodW-1:0]   tod_reg, tod_next;
    ecal_pkg::cal_t              cal_reg, cal_next;

    logic [ecal_pkg::DivInW-1:0] div_in;
    logic [ecal_pkg::RecW-1:0]   recip;
    logic [ecal_pkg::ProdW-1:0]  prod;
    logic [ecal_pkg::DaysW-1:0]  div_quo;
    logic [ecal_pkg::QdW-1:0]    qd;
    logic [ecal_pkg::EpochW-1:0] rem;
    logic                        leap;
    logic [8:0]                  ylen;
    logic [4:0]                  mlen;
    logic                        year_fits;
    logic                        mon_fits;

    // Divider operands: the pre-shifted dividend and the matching reciprocal.
    always_comb begin
        div_in = '0;
        recip  = '0;
        unique case (ctrl.dsel)
            ecal_pkg::DSEL_DAY: begin
                div_in = ecal_pkg::DivInW'(num_reg >> ecal_pkg::PreDay);
                recip  = ecal_pkg::RecipDay;
            end
            ecal_pkg::DSEL_WEEK: begin
                div_in = ecal_pkg::DivInW'(num_reg >> ecal_pkg::PreWeek);
                recip  = ecal_pkg::RecipWeek;
            end
            ecal_pkg::DSEL_HOUR: begin
                div_in = ecal_pkg::DivInW'(num_reg >> ecal_pkg::PreHour);
                recip  = ecal_pkg::RecipHour;
            end
            ecal_pkg::DSEL_MIN: begin
                div_in = ecal_pkg::DivInW'(num_reg >> ecal_pkg::PreMin);
                recip  = ecal_pkg::RecipMin;
            end
            default: begin
            end
        endcase
    end

    assign prod = ecal_pkg::ProdW'(div_in) * ecal_pkg::ProdW'(recip);

    // Quotient: the product shifted down by the divisor's scale.
    always_comb begin
        div_quo = '0;
        unique case (ctrl.dsel)
            ecal_pkg::DSEL_DAY:  div_quo = prod[ecal_pkg::PostDay +: ecal_pkg::DaysW];
            ecal_pkg::DSEL_WEEK: div_quo = prod[ecal_pkg::PostWeek +: ecal_pkg::DaysW];
            ecal_pkg::DSEL_HOUR: div_quo = prod[ecal_pkg::PostHour +: ecal_pkg::DaysW];
            ecal_pkg::DSEL_MIN:  div_quo = prod[ecal_pkg::PostMin +: ecal_pkg::DaysW];
            default:             div_quo = '0;
        endcase
    end

    // Remainder of the registered quotient against the same divisor.
    assign qd  = ecal_pkg::QdW'(quo_reg) * ecal_pkg::QdW'(ecal_pkg::divisor(ctrl.dsel));
    assign rem = num_reg - qd[ecal_pkg::EpochW-1:0];

    // Leap rule; within years 1970 to 2038 only the divisible-by-four test matters,
    // and 1900 (offset zero) is excluded as a century.
    assign leap = (cal_reg.years_since_1900[1:0] == 2'd0) && (cal_reg.years_since_1900 != 8'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = ecal_pkg::month_len(cal_reg.month_index)
                + {4'd0, leap && (cal_reg.month_index == 4'd1)};

    assign year_fits = days_reg < {6'd0, ylen};
    assign mon_fits  = days_reg < {10'd0, mlen};

    always_comb begin
        stat.fits = (ctrl.op == ecal_pkg::OP_MONTH) ? mon_fits : year_fits;
    end

    // Operation decode.
    always_comb begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        days_next = days_reg;
        tod_next  = tod_reg;
        cal_next  = cal_reg;
        unique case (ctrl.op)
            ecal_pkg::OP_IDLE: begin
                if (ctrl.go) begin
                    num_next                  = epoch_seconds;
                    cal_next.years_since_1900 = ecal_pkg::FirstYearOff;
                    cal_next.month_index      = 4'd0;
                end
            end
            ecal_pkg::OP_DIV: begin
                quo_next = div_quo;
            end
            ecal_pkg::OP_SAVE_DAYS: begin
                days_next = quo_reg;
                tod_next  = rem[ecal_pkg::TodW-1:0];
                num_next  = ecal_pkg::EpochW'(quo_reg) + ecal_pkg::EpochW'(ecal_pkg::EpochWeekday);
            end
            ecal_pkg::OP_SAVE_WDAY: begin
                cal_next.weekday = rem[2:0];
                num_next         = ecal_pkg::EpochW'(tod_reg);
            end
            ecal_pkg::OP_SAVE_HOUR: begin
                cal_next.hour = quo_reg[4:0];
                num_next      = rem;
            end
            ecal_pkg::OP_SAVE_MS: begin
                cal_next.minute = quo_reg[5:0];
                cal_next.second = rem[5:0];
            end
            ecal_pkg::OP_YEAR: begin
                if (year_fits) begin
                    cal_next.day_of_year = days_reg[8:0];
                end else begin
                    days_next                 = days_reg - {6'd0, ylen};
                    cal_next.years_since_1900 = cal_reg.years_since_1900 + 8'd1;
                end
            end
            ecal_pkg::OP_MONTH: begin
                if (mon_fits) begin
                    cal_next.day_of_month = days_reg[4:0] + 5'd1;
                end else begin
                    days_next            = days_reg - {10'd0, mlen};
                    cal_next.month_index = cal_reg.month_index + 4'd1;
                end
            end
            ecal_pkg::OP_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // Working registers hold payload only and need no reset.
    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        days_reg <= days_next;
        tod_reg  <= tod_next;
        cal_reg  <= cal_next;
    end

    assign cal = cal_reg;

endmodule

`default_nettype wire

[rtl/core/epoch_seconds_to_utc_calendar.sv]
// Top level of the epoch-to-calendar converter: microcode sequencer and result register.
`default_nettype none

// Converts a 31-bit count of seconds since 1970-01-01 00:00:00 UTC into the broken-down
// UTC calendar time, using the Gregorian leap rules. One result item comes out for each
// input item. A small microcode program drives one shared divider that works by
// reciprocal multiplication (days, weekday, hour, minute and second, two steps per
// division), then walks whole years and whole months, one per cycle. The year walk covers
// Y years past 1970 (0 to 68) and the month walk M months (0 to 11), so the year walk
// dominates for late dates. Items are converted one at a time; the input is ready again
// in the cycle after the result is loaded into the output register.

module epoch_seconds_to_utc_calendar (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] epoch_seconds, [31] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // second, minute, hour, day_of_month, month_index,
                                        // years_since_1900, day_of_year, weekday; [47:46] zero
);

    logic [ecal_pkg::PcW-1:0] pc_reg, pc_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    ecal_pkg::cal_t           out_reg, out_next;

    ecal_pkg::ucode_t cw;
    ecal_pkg::ctrl_t  ctrl;
    ecal_pkg::stat_t  stat;
    ecal_pkg::cal_t   cal;
    logic             take;
    logic             out_free;

    assign cw       = ecal_pkg::ucode_rom(pc_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Condition select for the step's jump.
    always_comb begin
        take = 1'b0;
        unique case (cw.cond)
            ecal_pkg::COND_ALWAYS:   take = 1'b1;
            ecal_pkg::COND_IN:       take = s_tvalid;
            ecal_pkg::COND_FITS:     take = stat.fits;
            ecal_pkg::COND_OUT_FREE: take = out_free;
            default:                 take = 1'b0;
        endcase
    end

    // Program counter and output register.
    always_comb begin
        pc_next       = take ? cw.target : pc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        if (cw.op == ecal_pkg::OP_EMIT && take) begin
            m_tvalid_next = 1'b1;
            out_next      = cal;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        out_reg <= out_next;
    end

    assign ctrl.op   = cw.op;
    assign ctrl.dsel = cw.dsel;
    assign ctrl.go   = take;

    ecal_dp u_dp (
        .aclk          (aclk),
        .epoch_seconds (s_tdata[ecal_pkg::EpochW-1:0]),
        .ctrl          (ctrl),
        .stat          (stat),
        .cal           (cal)
    );

    assign s_tready = (cw.op == ecal_pkg::OP_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg};

`ifndef SYNTHESIS
    // An accepted item occupies the sequencer, so the next cycle cannot take another.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a conversion is running");

    // A new result appears only from the emit step of the program.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && m_tvalid_next) |-> (cw.op == ecal_pkg::OP_EMIT))
        else $error("result raised outside the emit step");

    // The program counter stays within the program.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= ecal_pkg::LastPc)
        else $error("program counter beyond the last step");

    // A stalled result item keeps its data until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the epoch-seconds to UTC calendar converter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IdleLimit = 3000;
    localparam int unsigned SettleCycles = 200;
    localparam logic [30:0] LatestEpoch = 31'h7FFF_FFFF;
    localparam int unsigned DaysInRange = 24855;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [30:0] epoch_seconds, [31] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // second, minute, hour, day_of_month, month_index,
                            // years_since_1900, day_of_year, weekday; [47:46] zero

    ecal_pkg::cal_t pending_dates[$];
    int unsigned    error_count;
    int unsigned    quiet_cycles;
    bit             no_gaps;

    epoch_seconds_to_utc_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Gregorian leap rule.
    function automatic bit is_leap(input int unsigned year);
        return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    endfunction

    function automatic int unsigned year_days(input int unsigned year);
        return is_leap(year) ? 366 : 365;
    endfunction

    // Breaks a count of seconds since the epoch into calendar fields.
    function automatic ecal_pkg::cal_t calendar_of_epoch(input logic [30:0] secs);
        int unsigned    feb_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int unsigned    days;
        int unsigned    tod;
        int unsigned    year;
        int unsigned    left;
        int unsigned    mon;
        int unsigned    len;
        ecal_pkg::cal_t cal;
        days = secs / 86400;
        tod  = secs % 86400;
        year = 1970;
        left = days;
        while (left >= year_days(year)) begin
            left -= year_days(year);
            year++;
        end
        cal.day_of_year = 9'(left);
        mon = 0;
        for (int m = 0; m < 12; m++) begin
            len = feb_days[m];
            if (m == 1 && is_leap(year)) begin
                len = 29;
            end
            mon = m;
            if (left < len) begin
                break;
            end
            left -= len;
        end
        cal.second           = 6'(tod % 60);
        cal.minute           = 6'((tod / 60) % 60);
        cal.hour             = 5'(tod / 3600);
        cal.day_of_month     = 5'(left + 1);
        cal.month_index      = 4'(mon);
        cal.years_since_1900 = 8'(year - 1900);
        cal.weekday          = 3'((days + 4) % 7);
        return cal;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Sends one item and waits for its acceptance; tvalid stays high when no gap follows.
    task automatic send_epoch(input logic [30:0] secs);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, secs};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Holds off the sender until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Random epoch, mostly near a year, month, day, hour or minute boundary.
    function automatic logic [30:0] boundary_epoch();
        int unsigned year;
        int unsigned day;
        int unsigned tod;
        longint      secs;
        year = $urandom_range(1970, 2037);
        day  = 0;
        for (int unsigned y = 1970; y < year; y++) begin
            day += year_days(y);
        end
        case ($urandom_range(0, 5))
            0: day += 0;
            1: day += 58;
            2: day += 59;
            3: day += 60;
            4: day += year_days(year) - 1;
            default: day += $urandom_range(0, year_days(year) - 1);
        endcase
        case ($urandom_range(0, 4))
            0: tod = 0;
            1: tod = 86399;
            2: tod = 3599 + $urandom_range(0, 1);
            3: tod = 60 * $urandom_range(0, 1439) + 59;
            default: tod = $urandom_range(0, 86399);
        endcase
        secs = longint'(day) * 86400 + tod;
        if (secs > longint'(LatestEpoch)) begin
            secs = LatestEpoch - $urandom_range(0, 86399);
        end
        return 31'(secs);
    endfunction

    // Field extremes, leap days, year ends and the last second of each month.
    task automatic test_directed();
        int unsigned month_ends[12] = '{31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};
        send_epoch(31'd0);
        send_epoch(31'd86399);
        send_epoch(31'd86400);
        send_epoch(LatestEpoch);
        send_epoch(31'd68169599);     // 1972-02-28 23:59:59
        send_epoch(31'd68169600);     // 1972-02-29, first leap day
        send_epoch(31'd68256000);     // 1972-03-01
        send_epoch(31'd94694399);     // 1972-12-31 23:59:59, day 365 of a leap year
        send_epoch(31'd36633600);     // 1971-03-01, common year
        send_epoch(31'd951782400);    // 2000-02-29, century leap year
        send_epoch(31'd978307199);    // 2000-12-31 23:59:59
        send_epoch(31'd978307200);    // 2001-01-01
        send_epoch(31'h5555_5555);
        send_epoch(31'h2AAA_AAAA);
        // Last second of every month of 2024.
        foreach (month_ends[m]) begin
            send_epoch(31'(64'd1704067200 + 64'(month_ends[m]) * 86400 - 1));
        end
    endtask

    task automatic test_random_epochs(input int unsigned count);
        repeat (count) send_epoch(31'($urandom()));
    endtask

    task automatic test_calendar_edges(input int unsigned count);
        repeat (count) send_epoch(boundary_epoch());
    endtask

    // Back-to-back items with short year walks and no stalls on either side.
    task automatic test_back_to_back(input int unsigned count);
        no_gaps = 1'b1;
        repeat (count) send_epoch(31'($urandom_range(0, 3 * 366 * 86400)));
        wait_drained();
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pauses(input int unsigned rounds);
        repeat (rounds) begin
            repeat (10) send_epoch(31'($urandom_range(0, DaysInRange) * 86400
                                       + $urandom_range(0, 86399)) & LatestEpoch);
            wait_drained();
        end
    endtask

    // Receiver backpressure.
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            int unsigned stall;
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Predicts on every accepted input item and checks every accepted result item.
    always @(posedge aclk) begin
        ecal_pkg::cal_t got;
        ecal_pkg::cal_t want;
        if (aresetn && s_tvalid && s_tready) begin
            pending_dates.push_back(calendar_of_epoch(s_tdata[30:0]));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("result item with none expected", 1, 0);
            end else begin
                want = pending_dates.pop_front();
                got  = m_tdata[45:0];
                if (got.second != want.second)
                    report_mismatch("second", got.second, want.second);
                if (got.minute != want.minute)
                    report_mismatch("minute", got.minute, want.minute);
                if (got.hour != want.hour)
                    report_mismatch("hour", got.hour, want.hour);
                if (got.day_of_month != want.day_of_month)
                    report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
                if (got.month_index != want.month_index)
                    report_mismatch("month_index", got.month_index, want.month_index);
                if (got.years_since_1900 != want.years_since_1900)
                    report_mismatch("years_since_1900", got.years_since_1900,
                                    want.years_since_1900);
                if (got.day_of_year != want.day_of_year)
                    report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
                if (got.weekday != want.weekday)
                    report_mismatch("weekday", got.weekday, want.weekday);
                if (m_tdata[47:46] != 2'b00)
                    report_mismatch("padding bits", m_tdata[47:46], 0);
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IdleLimit) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        error_count  = 0;
        quiet_cycles = 0;
        no_gaps      = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_epochs(700);
        test_calendar_edges(480);
        test_back_to_back(100);
        test_drain_pauses(10);

        wait_drained();
        repeat (SettleCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
